// ----- hw/rtl/ile_pkg.sv -----
// Indexed list engine: shared constants, opcode and state enums, bus structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  // one rotation step of the cell chain plus the tail-side write
  typedef struct packed {
    logic              step;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [WORD_W-1:0] wr_data;
  } ile_bus_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic [IDX_W-1:0]  found_position;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } ile_result_t;

endpackage

// ----- hw/rtl/ile_cell.sv -----
// Indexed list engine: one storage cell of the shifting chain.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_cell
  import ile_pkg::*;
(
  input  logic              clk_i,
  input  logic              step_i,
  input  logic              load_i,
  input  logic [WORD_W-1:0] load_data_i,
  input  logic [WORD_W-1:0] shift_data_i,
  output logic [WORD_W-1:0] data_o
);

  logic [WORD_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      data_q <= load_i ? load_data_i : shift_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/ile_ctrl.sv -----
// Indexed list engine: request decode, scan sequencer and result register.
// Drives the cell chain through ile_bus_t; depends on ile_pkg.
`timescale 1ns / 1ps

module ile_ctrl
  import ile_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] head_i,
  output ile_bus_t          bus_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ile_result_t       result_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  op_e               op_q, op_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [WORD_W-1:0] hold_q, hold_d;
  logic [WORD_W-1:0] rd_q, rd_d;
  logic [IDX_W-1:0]  fp_q, fp_d;
  logic              found_q, found_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic              out_valid_q, out_valid_d;
  ile_result_t       res_q, res_d;

  logic              out_load;
  logic              last_step;
  logic [CNT_W-1:0]  kx;
  logic              in_list;
  logic              hit;
  logic [CNT_W-1:0]  tgt;

  assign out_load  = !out_valid_q || !out_stall_i;
  assign last_step = (k_q == IDX_W'(DEPTH - 1));
  assign kx        = CNT_W'(k_q);
  assign in_list   = (kx < cnt_q);
  assign hit       = in_list && (head_i == val_q);
  // removed words pull the write slot down from the tail
  assign tgt       = CNT_W'(DEPTH - 1) - r_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (last_step) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = 1'b1;
    bus_o.step    = 1'b0;
    bus_o.wr_en   = 1'b0;
    bus_o.wr_idx  = tgt[IDX_W-1:0];
    bus_o.wr_data = head_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_SCAN: begin
        bus_o.step  = 1'b1;
        bus_o.wr_en = 1'b1;
        case (op_q)
          OP_PUSH, OP_INSERT: begin
            if (ok_q) begin
              if (kx == pos_q) begin
                bus_o.wr_data = val_q;
              end else if (kx > pos_q) begin
                bus_o.wr_data = hold_q;
              end
            end
          end
          OP_DELETE: begin
            if (ok_q && kx == pos_q) bus_o.wr_en = 1'b0;
          end
          OP_REMOVE: begin
            if (hit) bus_o.wr_en = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d       = cnt_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ok_d        = ok_q;
    k_d         = k_q;
    r_d         = r_q;
    hold_d      = hold_q;
    rd_d        = rd_q;
    fp_d        = fp_q;
    found_d     = found_q;
    st_d        = st_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(opcode_i);
          val_d   = value_i;
          pos_d   = position_i;
          ok_d    = 1'b1;
          st_d    = ST_OK;
          k_d     = '0;
          r_d     = '0;
          rd_d    = '0;
          fp_d    = '0;
          found_d = 1'b0;
          case (op_e'(opcode_i))
            OP_PUSH: begin
              pos_d = cnt_q;
              if (cnt_q == CNT_W'(DEPTH)) begin
                ok_d = 1'b0;
                st_d = ST_FULL;
              end
            end
            OP_INSERT: begin
              if (position_i > cnt_q) begin
                ok_d = 1'b0;
                st_d = ST_RANGE;
              end else if (cnt_q == CNT_W'(DEPTH)) begin
                ok_d = 1'b0;
                st_d = ST_FULL;
              end
            end
            OP_POP: begin
              pos_d = cnt_q - CNT_W'(1);
              if (cnt_q == '0) begin
                ok_d = 1'b0;
                st_d = ST_EMPTY;
              end
            end
            OP_DELETE, OP_READ: begin
              if (position_i >= cnt_q) begin
                ok_d = 1'b0;
                st_d = ST_RANGE;
              end
            end
            OP_REMOVE: ;
            OP_FIND: st_d = ST_NOTFOUND;
            default: ok_d = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        k_d    = k_q + IDX_W'(1);
        hold_d = head_i;
        case (op_q)
          OP_DELETE: begin
            if (ok_q && kx == pos_q) r_d = r_q + CNT_W'(1);
          end
          OP_REMOVE: begin
            if (hit) r_d = r_q + CNT_W'(1);
          end
          OP_POP, OP_READ: begin
            if (ok_q && kx == pos_q) rd_d = head_i;
          end
          OP_FIND: begin
            if (hit && !found_q) begin
              found_d = 1'b1;
              fp_d    = k_q;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        if (out_load) begin
          case (op_q)
            OP_PUSH, OP_INSERT: begin
              if (ok_q) cnt_d = cnt_q + CNT_W'(1);
            end
            OP_POP, OP_DELETE: begin
              if (ok_q) cnt_d = cnt_q - CNT_W'(1);
            end
            OP_REMOVE: cnt_d = cnt_q - r_q;
            default: ;
          endcase
          res_d.read_value     = rd_q;
          res_d.found_position = fp_q;
          res_d.count          = cnt_d;
          res_d.status         = (op_q == OP_FIND && found_q) ? ST_OK : st_q;
          out_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    ok_q    <= ok_d;
    k_q     <= k_d;
    r_q     <= r_d;
    hold_q  <= hold_d;
    rd_q    <= rd_d;
    fp_q    <= fp_d;
    found_q <= found_d;
    st_q    <= st_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ----- hw/rtl/indexed_list_engine.sv -----
// Indexed list engine top level: DEPTH-cell shifting chain plus controller.
// Depends on ile_pkg, ile_cell and ile_ctrl.
//
//   channel | dir | handshake             | word
//   in      | in  | in_valid_i/in_stall_o | opcode_i, position_i, value_i
//   out     | out | out_valid_o/out_stall_i | read_value_o, found_position_o,
//           |     |                       | count_o, status_o
//
// Every request rotates the whole chain once: the controller accepts it in S_IDLE,
// steps the cells in S_SCAN and loads the result register in S_FIN, and takes
// no new request until it is back in S_IDLE.
// Reset clears state, count and out_valid; cells stay undefined until written.
// A stalled result holds in the output register; a new request is accepted
// meanwhile, and a finished one waits in its last state until the register frees.
`timescale 1ns / 1ps

module indexed_list_engine
  import ile_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic [WORD_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] read_value_o,
  output logic [IDX_W-1:0]  found_position_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [STAT_W-1:0] status_o
);

  ile_bus_t          bus;
  ile_result_t       result;
  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_load;

  ile_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .head_i      (cell_data[0]),
    .bus_o       (bus),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] shift_in;

    assign cell_load[g] = bus.wr_en && (bus.wr_idx == IDX_W'(g));

    if (g == DEPTH - 1) begin : g_tail
      assign shift_in = bus.wr_data;
    end else begin : g_body
      assign shift_in = cell_data[g+1];
    end

    ile_cell u_cell (
      .clk_i        (clk_i),
      .step_i       (bus.step),
      .load_i       (cell_load[g]),
      .load_data_i  (bus.wr_data),
      .shift_data_i (shift_in),
      .data_o       (cell_data[g])
    );
  end

  assign read_value_o     = result.read_value;
  assign found_position_o = result.found_position;
  assign count_o          = result.count;
  assign status_o         = result.status;

  // at most one write slot per step
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_load))
    else $error("more than one cell loaded");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(DEPTH)))
    else $error("count beyond capacity");

  a_notfound_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOTFOUND) |-> (found_position_o == '0))
    else $error("position reported on a miss");

endmodule

// ----- verif/ile_checker.sv -----
// Checker for the indexed list engine: watches both channels, keeps its own copy
// of the list, predicts one result word per request and compares it field by field.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_checker
  import ile_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [WORD_W-1:0] read_value_o,
  input  logic [IDX_W-1:0]  found_position_o,
  input  logic [CNT_W-1:0]  count_o,
  input  logic [STAT_W-1:0] status_o,
  output int                fail_count,
  output int                pending,
  output int                stored_count
);

  logic [WORD_W-1:0] list_words [DEPTH];
  int                list_len;
  int                errors;
  ile_result_t       pending_results [$];

  function automatic ile_result_t predict_outcome(input logic [OP_W-1:0] op,
                                                  input logic [CNT_W-1:0] pos,
                                                  input logic [WORD_W-1:0] val);
    ile_result_t r;
    int          i;
    int          w;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (int'(pos) > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[pos[IDX_W-1:0]] = val;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.read_value = list_words[list_len];
        end
      end
      OP_DELETE: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] != val) begin
            list_words[w] = list_words[i];
            w++;
          end
        end
        list_len = w;
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == val) begin
            r.found_position = i[IDX_W-1:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_READ: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.read_value = list_words[pos[IDX_W-1:0]];
      end
      default: ;
    endcase
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ile_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      errors   = 0;
      pending_results.delete();
      fail_count   <= 0;
      pending      <= 0;
      stored_count <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result word, expected none, actual %0h %0h %0h %0h",
                   $time, read_value_o, found_position_o, count_o, status_o);
        end else begin
          want = pending_results.pop_front();
          check_field("read_value", want.read_value, read_value_o);
          check_field("found_position", WORD_W'(want.found_position),
                      WORD_W'(found_position_o));
          check_field("count", WORD_W'(want.count), WORD_W'(count_o));
          check_field("status", WORD_W'(want.status), WORD_W'(status_o));
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(predict_outcome(opcode_i, position_i, value_i));
      fail_count   <= errors;
      pending      <= pending_results.size();
      stored_count <= list_len;
    end
  end

endmodule

// ----- verif/indexed_list_engine_tb.sv -----
// Testbench top for the indexed list engine: clock, reset, request stimulus,
// result-side stall pattern and the verdict. Depends on ile_pkg and ile_checker.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_WORDS = 320;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 10;

  logic              clk_i;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   opcode;
  logic [CNT_W-1:0]  position;
  logic [WORD_W-1:0] value;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] read_value;
  logic [IDX_W-1:0]  found_position;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] status;

  int fail_count;
  int pending;
  int stored_count;
  int cycles;
  bit quiet;
  bit hold_long;

  indexed_list_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .position_i       (position),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_value_o     (read_value),
    .found_position_o (found_position),
    .count_o          (count),
    .status_o         (status)
  );

  ile_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .position_i       (position),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_value_o     (read_value),
    .found_position_o (found_position),
    .count_o          (count),
    .status_o         (status),
    .fail_count       (fail_count),
    .pending          (pending),
    .stored_count     (stored_count)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                           input logic [WORD_W-1:0] val);
    @(negedge clk_i);
    in_valid = 1'b1;
    opcode   = op;
    position = pos;
    value    = val;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  endtask

  // small pool and extremes give repeats for find and remove
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return WORD_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  // receiver: random stall bursts, one long hold on request, none in the last part
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall = 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    logic [OP_W-1:0] grow_ops [10];
    logic [OP_W-1:0] shrink_ops [10];
    logic [OP_W-1:0] op;
    logic [CNT_W-1:0] pos;
    int r;
    grow_ops   = '{OP_PUSH, OP_PUSH, OP_PUSH, OP_PUSH, OP_INSERT, OP_INSERT,
                   OP_FIND, OP_READ, OP_POP, OP_REMOVE};
    shrink_ops = '{OP_POP, OP_POP, OP_POP, OP_DELETE, OP_DELETE, OP_REMOVE,
                   OP_FIND, OP_READ, OP_PUSH, OP_INSERT};
    cycles    = 0;
    quiet     = 1'b0;
    hold_long = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    opcode    = OP_PUSH;
    position  = '0;
    value     = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // empty list corner cases
    send_word(OP_POP,    7'd0,   32'h0);
    send_word(OP_READ,   7'd0,   32'h0);
    send_word(OP_DELETE, 7'd0,   32'h0);
    send_word(OP_FIND,   7'd0,   32'h0);
    send_word(OP_REMOVE, 7'd0,   32'h0);
    send_word(OP_INSERT, 7'd1,   32'h1);
    // build a short list with extreme words
    send_word(OP_INSERT, 7'd0,   32'h8000_0000);
    send_word(OP_PUSH,   7'd127, 32'h7fff_ffff);
    send_word(OP_PUSH,   7'd0,   32'h0);
    send_word(OP_PUSH,   7'd0,   32'hffff_ffff);
    send_word(OP_INSERT, 7'd1,   32'h0000_0005);
    send_word(OP_INSERT, 7'd5,   32'h0000_0005);
    send_word(OP_FIND,   7'd0,   32'hffff_ffff);
    send_word(OP_FIND,   7'd0,   32'h0001_2345);
    send_word(OP_READ,   7'd0,   32'h0);
    send_word(OP_READ,   7'd6,   32'h0);
    send_word(OP_READ,   7'd127, 32'h0);
    send_word(OP_DELETE, 7'd1,   32'h0);
    send_word(OP_REMOVE, 7'd0,   32'h0000_0005);
    send_word(OP_REMOVE, 7'd0,   32'h0bad_cafe);
    send_word(OP_UNUSED, 7'd127, 32'hffff_ffff);
    send_word(OP_DELETE, 7'd3,   32'h0);
    send_word(OP_POP,    7'd0,   32'h0);
    drain();

    // fill to capacity, then the full-list corner cases
    repeat (DEPTH) send_word(OP_PUSH, 7'($urandom_range(0, 127)), pick_value());
    send_word(OP_PUSH,   7'd0,  $urandom);
    send_word(OP_INSERT, 7'd10, $urandom);
    send_word(OP_INSERT, 7'd64, $urandom);
    send_word(OP_INSERT, 7'd65, $urandom);
    send_word(OP_READ,   7'd63, 32'h0);
    send_word(OP_READ,   7'd64, 32'h0);
    send_word(OP_FIND,   7'd0,  32'hffff_ffff);
    send_word(OP_DELETE, 7'd63, 32'h0);
    send_word(OP_INSERT, 7'd63, 32'h8000_0000);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 120) hold_long = 1'b1;
      if (i == 240) drain();
      if (i == RANDOM_WORDS - 60) quiet = 1'b1;
      r  = $urandom_range(0, 9);
      op = ((i / 70) % 2 == 0) ? grow_ops[r] : shrink_ops[r];
      if ($urandom_range(0, 24) == 0) op = OP_UNUSED;
      r = $urandom_range(0, 9);
      if (r < 7)      pos = 7'($urandom_range(0, stored_count));
      else if (r < 9) pos = 7'($urandom_range(0, DEPTH));
      else            pos = 7'($urandom_range(0, 127));
      send_word(op, pos, pick_value());
      sender_gap();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
